### design/bda_pkg.sv
// Shared constants, types and the shift-and-add-3 step for the binary to decimal ASCII converter.
package bda_pkg;

    localparam int VALUE_W         = 32;
    localparam int VALUE_DIGITS    = 10;
    localparam int MAX_DIGITS      = 10;
    localparam int DIGIT_LIMIT     = (MAX_DIGITS > VALUE_DIGITS) ? VALUE_DIGITS :
                                     ((MAX_DIGITS < 1) ? 1 : MAX_DIGITS);
    localparam int DIGIT_W         = 4;
    localparam int BCD_W           = VALUE_DIGITS * DIGIT_W;
    localparam int WORK_W          = BCD_W + VALUE_W;
    localparam int STEPS_PER_STAGE = 4;
    localparam int STAGES          = VALUE_W / STEPS_PER_STAGE;
    localparam int IDX_W           = $clog2(VALUE_DIGITS);
    localparam int CHAR_W          = 6;

    localparam logic [DIGIT_W-1:0] DIGIT_ADJ_MIN = 4'd5;
    localparam logic [DIGIT_W-1:0] DIGIT_ADJ     = 4'd3;
    localparam logic [1:0]         CHAR_PREFIX   = 2'b11;

    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [BCD_W-1:0]   t_bcd;
    typedef logic [WORK_W-1:0]  t_work;
    typedef logic [IDX_W-1:0]   t_idx;

    // One shift-and-add-3 step: adjust every BCD digit, then shift left by one.
    function automatic t_work dd_step(t_work w);
        t_work a;
        a = w;
        for (int i = 0; i < VALUE_DIGITS; i++) begin
            if (a[VALUE_W + i*DIGIT_W +: DIGIT_W] >= DIGIT_ADJ_MIN) begin
                a[VALUE_W + i*DIGIT_W +: DIGIT_W] =
                    a[VALUE_W + i*DIGIT_W +: DIGIT_W] + DIGIT_ADJ;
            end
        end
        return {a[WORK_W-2:0], 1'b0};
    endfunction

    function automatic t_work dd_stage(t_work w);
        t_work a;
        a = w;
        for (int s = 0; s < STEPS_PER_STAGE; s++) begin
            a = dd_step(a);
        end
        return a;
    endfunction

endpackage

### design/bda_conv.sv
// Pipelined binary to BCD conversion, four shift-and-add-3 steps per stage.
module bda_conv (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  bda_pkg::t_value     i_value,
    output logic                o_valid,
    input  logic                i_ready,
    output bda_pkg::t_bcd       o_bcd
);

    logic          r_valid [bda_pkg::STAGES];
    bda_pkg::t_work r_work [bda_pkg::STAGES];
    logic          stage_ready [bda_pkg::STAGES];

    // A stage takes new data when it is empty or its content moves on.
    always_comb begin
        stage_ready[bda_pkg::STAGES-1] = !r_valid[bda_pkg::STAGES-1] || i_ready;
        for (int k = bda_pkg::STAGES - 2; k >= 0; k--) begin
            stage_ready[k] = !r_valid[k] || stage_ready[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < bda_pkg::STAGES; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else begin
            if (stage_ready[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int k = 1; k < bda_pkg::STAGES; k++) begin
                if (stage_ready[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_ready[0]) begin
            r_work[0] <= bda_pkg::dd_stage({{bda_pkg::BCD_W{1'b0}}, i_value});
        end
        for (int k = 1; k < bda_pkg::STAGES; k++) begin
            if (stage_ready[k]) begin
                r_work[k] <= bda_pkg::dd_stage(r_work[k-1]);
            end
        end
    end

    assign o_ready = stage_ready[0];
    assign o_valid = r_valid[bda_pkg::STAGES-1];
    assign o_bcd   = r_work[bda_pkg::STAGES-1][bda_pkg::WORK_W-1 -: bda_pkg::BCD_W];

    // A stalled final stage holds its item.
    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_bcd)))
        else $error("final stage lost or changed a stalled item");

    // A transfer into stage zero shows up as valid there on the next edge.
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_valid[0])
        else $error("accepted item not captured in first stage");

    // The top BCD digit of a 32-bit value never exceeds four.
    a_top_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_bcd[bda_pkg::BCD_W-1 -: bda_pkg::DIGIT_W] <= 4'd4))
        else $error("top BCD digit out of range");

endmodule

### design/binary_to_decimal_ascii.sv
// Top level: 32-bit binary value in, decimal ASCII digits out, most significant first.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------
//  input    | i_valid / o_ready    | i_value[31:0]
//  output   | o_valid / i_ready    | o_digit_char[5:0], o_last
//
// A value passes through the eight conversion pipeline stages (four add-3/shift steps each),
// then the emitter sends one character per cycle while i_ready is high, 1 to 10 per value.
// Sustained rate is set by the emitter, one digit per cycle; the pipeline takes a new value
// every cycle while the emitter is busy, up to its eight stages.
// Reset clears the stage valid bits and the emitter; stalls on either side hold all data.
module binary_to_decimal_ascii (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [bda_pkg::VALUE_W-1:0] i_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [bda_pkg::CHAR_W-1:0]  o_digit_char,
    output logic                        o_last
);

    logic          conv_valid;
    logic          conv_ready;
    bda_pkg::t_bcd conv_bcd;
    bda_pkg::t_idx lead_idx;
    bda_pkg::t_idx start_idx;

    logic          r_busy;
    logic          n_busy;
    bda_pkg::t_idx r_idx;
    bda_pkg::t_idx n_idx;
    bda_pkg::t_bcd r_bcd;

    logic          out_xfer;
    logic          load;
    logic [bda_pkg::DIGIT_W-1:0] cur_digit;

    bda_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_value (i_value),
        .o_valid (conv_valid),
        .i_ready (conv_ready),
        .o_bcd   (conv_bcd)
    );

    // Find the highest nonzero digit; zero gives digit 0, clamp to the digit limit.
    always_comb begin
        lead_idx = '0;
        for (int i = 0; i < bda_pkg::VALUE_DIGITS; i++) begin
            if (conv_bcd[i*bda_pkg::DIGIT_W +: bda_pkg::DIGIT_W] != '0) begin
                lead_idx = bda_pkg::t_idx'(i);
            end
        end
        if (lead_idx > bda_pkg::t_idx'(bda_pkg::DIGIT_LIMIT - 1)) begin
            start_idx = bda_pkg::t_idx'(bda_pkg::DIGIT_LIMIT - 1);
        end else begin
            start_idx = lead_idx;
        end
    end

    assign out_xfer   = r_busy && i_ready;
    assign conv_ready = !r_busy || (out_xfer && (r_idx == '0));
    assign load       = conv_valid && conv_ready;

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (out_xfer) begin
            if (r_idx == '0) begin
                n_busy = 1'b0;
            end else begin
                n_idx = r_idx - 1'b1;
            end
        end
        if (load) begin
            n_busy = 1'b1;
            n_idx  = start_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bcd <= conv_bcd;
        end
    end

    assign cur_digit    = r_bcd[{r_idx, 2'b00} +: bda_pkg::DIGIT_W];
    assign o_valid      = r_busy;
    assign o_digit_char = {bda_pkg::CHAR_PREFIX, cur_digit};
    assign o_last       = (r_idx == '0);

    // The digit index of a run never goes above the digit limit.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= bda_pkg::t_idx'(bda_pkg::DIGIT_LIMIT - 1)))
        else $error("digit index beyond limit");

    // A transfer that is not the last keeps the run going with the next lower digit.
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && !o_last) |=> (r_busy && (r_idx == $past(r_idx) - 1'b1)))
        else $error("run broken before last digit");

    // Every emitted digit is a decimal digit.
    a_digit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (cur_digit <= 4'd9))
        else $error("emitted digit is not decimal");

endmodule

### test/binary_to_decimal_ascii_tb.sv
// Testbench for the binary to decimal ASCII converter: directed and random values in, digit stream checked.
`timescale 1ns / 1ps

module binary_to_decimal_ascii_tb;

    localparam logic [bda_pkg::CHAR_W-1:0] ASCII_ZERO = 6'd48;
    localparam int MAX_IDLE      = 10;
    localparam int RANDOM_VALUES = 135;
    localparam int DRAIN_CYCLES  = 30;

    typedef struct packed {
        logic [bda_pkg::CHAR_W-1:0] digit_char;
        logic                       last;
    } t_digit;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_valid = 1'b0;
    logic                         o_ready;
    logic [bda_pkg::VALUE_W-1:0]  i_value = '0;
    logic                         o_valid;
    logic                         i_ready = 1'b0;
    logic [bda_pkg::CHAR_W-1:0]   o_digit_char;
    logic                         o_last;

    bda_pkg::t_value value_q[$];
    t_digit          digit_expect_q[$];
    int              mismatches = 0;
    int              values_sent = 0;
    int              digits_seen = 0;
    int              send_idle = 0;
    int              recv_stall = 0;

    binary_to_decimal_ascii dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_digit_char (o_digit_char),
        .o_last       (o_last)
    );

    always #1 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Expand a value into its decimal characters, most significant first.
    function automatic void push_decimal_digits(input bda_pkg::t_value val);
        logic [3:0]      rev [bda_pkg::VALUE_DIGITS];
        bda_pkg::t_value rest;
        int              n;
        int              count;
        t_digit          d;
        rest = val;
        n = 0;
        do begin
            rev[n] = 4'(rest % 10);
            rest = rest / 10;
            n++;
        end while (rest != 0 && n < bda_pkg::VALUE_DIGITS);
        // Keep only the low-order digits when the digit limit is short.
        count = (n < bda_pkg::DIGIT_LIMIT) ? n : bda_pkg::DIGIT_LIMIT;
        for (int k = count - 1; k >= 0; k--) begin
            d.digit_char = ASCII_ZERO + bda_pkg::CHAR_W'(rev[k]);
            d.last = (k == 0);
            digit_expect_q.push_back(d);
        end
    endfunction

    function automatic int draw_idle(input int done, input int run);
        // Every third stretch of transfers runs without idling.
        if ((done / run) % 3 == 2) return 0;
        return $urandom_range(MAX_IDLE, 0);
    endfunction

    // Driver: present queued values, idling a random number of cycles between them.
    always @(posedge i_clk) begin
        int idle;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_idle <= $urandom_range(MAX_IDLE, 0);
        end else begin
            idle = send_idle;
            if (i_valid && o_ready) begin
                push_decimal_digits(i_value);
                values_sent++;
            end
            if (!i_valid || o_ready) begin
                if (idle > 0) begin
                    i_valid <= 1'b0;
                    send_idle <= idle - 1;
                end else if (value_q.size() > 0) begin
                    i_valid <= 1'b1;
                    i_value <= value_q.pop_front();
                    send_idle <= draw_idle(values_sent, 16);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each digit transfer, stalling ready at random.
    always @(posedge i_clk) begin
        int     stall;
        t_digit want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            recv_stall <= 0;
        end else begin
            stall = recv_stall;
            if (o_valid && i_ready) begin
                if (digit_expect_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected digit 0x%0h last %0b",
                                              o_digit_char, o_last));
                end else begin
                    want = digit_expect_q.pop_front();
                    if (o_digit_char !== want.digit_char)
                        report_mismatch($sformatf("digit_char 0x%0h, want 0x%0h",
                                                  o_digit_char, want.digit_char));
                    if (o_last !== want.last)
                        report_mismatch($sformatf("last %0b, want %0b",
                                                  o_last, want.last));
                end
                digits_seen++;
                stall = draw_idle(digits_seen, 24);
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                recv_stall <= stall - 1;
            end else begin
                i_ready <= 1'b1;
                recv_stall <= 0;
            end
        end
    end

    initial begin
        longint lo;
        longint hi;
        int     ndig;

        // Zero, one, the boundaries of every digit count, the top of the range and fixed bit patterns.
        value_q.push_back(32'd0);
        value_q.push_back(32'd1);
        lo = 1;
        for (int k = 1; k < bda_pkg::VALUE_DIGITS; k++) begin
            value_q.push_back(bda_pkg::t_value'(lo * 10 - 1));
            lo = lo * 10;
            value_q.push_back(bda_pkg::t_value'(lo));
        end
        value_q.push_back(32'hFFFF_FFFF);
        value_q.push_back(32'd4294967290);
        value_q.push_back(32'h8000_0000);
        value_q.push_back(32'hAAAA_AAAA);
        value_q.push_back(32'h5555_5555);

        // Spread most random values evenly over the digit counts.
        repeat (RANDOM_VALUES) begin
            if ($urandom_range(3, 0) == 0) begin
                value_q.push_back($urandom());
            end else begin
                ndig = $urandom_range(bda_pkg::VALUE_DIGITS, 1);
                lo = 1;
                for (int k = 1; k < ndig; k++) lo = lo * 10;
                hi = lo * 10 - 1;
                if (ndig == 1) lo = 0;
                if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
                value_q.push_back($urandom_range(bda_pkg::t_value'(hi),
                                                 bda_pkg::t_value'(lo)));
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (value_q.size() != 0 || i_valid) @(posedge i_clk);
        while (digit_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("FAILURE");
        $finish;
    end

endmodule

### binary_to_decimal_ascii.f
design/bda_pkg.sv
design/bda_conv.sv
design/binary_to_decimal_ascii.sv
test/binary_to_decimal_ascii_tb.sv
